// File: rtl/core/cts_pkg.sv
`default_nettype none

package cts_pkg;

  // Width of the remaining-days counter used by the month walk.
  localparam int unsigned LEFT_W = 11;

  // Largest day span that the walk accepts; larger spans saturate to it.
  localparam int unsigned MAX_SPAN_DAYS = 1023;

  // Clock field limits.
  localparam logic [4:0] HOURS_PER_DAY   = 5'd24;
  localparam logic [5:0] MINS_PER_HOUR   = 6'd60;
  localparam logic [5:0] SECS_PER_MINUTE = 6'd60;

  // Month numbers used by the wrap logic.
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Year limits of the signed 16-bit year and its floor remainder by 400 there.
  localparam logic signed [15:0] YEAR_MAX    = 16'sh7FFF;
  localparam logic signed [15:0] YEAR_MIN    = 16'sh8000;
  localparam logic [8:0]         YMOD_AT_MAX = 9'd367;
  localparam logic [8:0]         YMOD_AT_MIN = 9'd32;
  localparam logic [8:0]         YMOD_LAST   = 9'd399;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEC,
    ST_MIN,
    ST_HOUR,
    ST_YMOD,
    ST_WALK,
    ST_MONTH,
    ST_YEAR,
    ST_YMOD2,
    ST_FINISH
  } state_e;

  // Divisor selection for the shared divide unit.
  typedef enum logic [1:0] {
    DIV_60,
    DIV_24,
    DIV_12,
    DIV_400
  } div_sel_e;

  // Phases of one pass through the divide unit.
  typedef enum logic [1:0] {
    PH_LOAD,
    PH_MUL,
    PH_READ
  } div_phase_e;

  // Control of the divide unit.
  typedef struct packed {
    logic     load;
    logic     mul;
    div_sel_e sel;
  } dm_ctrl_t;

  // Result of one month step of the day walk.
  typedef struct packed {
    logic [3:0]              month;
    logic signed [15:0]      year;
    logic [8:0]              ymod;
    logic signed [7:0]       day;
    logic [LEFT_W-1:0]       left;
    logic                    done;
  } walk_t;

  // Divisor value.
  function automatic logic [8:0] div_value(div_sel_e sel);
    logic [8:0] d;
    case (sel)
      DIV_60:  d = 9'd60;
      DIV_24:  d = 9'd24;
      DIV_12:  d = 9'd12;
      DIV_400: d = 9'd400;
      default: d = 9'd60;
    endcase
    return d;
  endfunction

  // Reciprocal ceil(2^26 / d); exact for every biased operand below 2^17.
  function automatic logic [22:0] div_mult(div_sel_e sel);
    logic [22:0] m;
    case (sel)
      DIV_60:  m = 23'd1118482;
      DIV_24:  m = 23'd2796203;
      DIV_12:  m = 23'd5592406;
      DIV_400: m = 23'd167773;
      default: m = 23'd1118482;
    endcase
    return m;
  endfunction

  // Bias multiple K; the operand is raised by K*d so that it is never negative.
  function automatic logic [7:0] div_k(div_sel_e sel);
    logic [7:0] k;
    case (sel)
      DIV_60:  k = 8'd72;
      DIV_24:  k = 8'd48;
      DIV_12:  k = 8'd24;
      DIV_400: k = 8'd82;
      default: k = 8'd72;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] div_bias(div_sel_e sel);
    logic [15:0] b;
    case (sel)
      DIV_60:  b = 16'd4320;
      DIV_24:  b = 16'd1152;
      DIV_12:  b = 16'd288;
      DIV_400: b = 16'd32800;
      default: b = 16'd4320;
    endcase
    return b;
  endfunction

  // Leap year from the floor remainder of the year by 400.
  function automatic logic is_leap(logic [8:0] ymod);
    return (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200) &&
           (ymod != 9'd300);
  endfunction

  // Gregorian month length; month numbers outside 1..12 read as January.
  function automatic logic [4:0] days_in(logic [3:0] month, logic leap);
    logic [4:0] len;
    case (month)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR,
      MONTH_JUN,
      MONTH_SEP,
      MONTH_NOV: len = 5'd30;
      default:   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cts_if.sv
`default_nettype none

// Input channel: one date-time and one span per transaction.
interface cts_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] cur_year;
  logic [3:0]         cur_month;
  logic [4:0]         cur_day;
  logic [4:0]         cur_hour;
  logic [5:0]         cur_minute;
  logic [5:0]         cur_second;
  logic [7:0]         span_years;
  logic [7:0]         span_months;
  logic [9:0]         span_days;
  logic [9:0]         span_hours;
  logic [23:0]        span_min_sec;

  modport source (
    output valid, action, cur_year, cur_month, cur_day, cur_hour, cur_minute,
           cur_second, span_years, span_months, span_days, span_hours, span_min_sec,
    input  ready
  );

  modport sink (
    input  valid, action, cur_year, cur_month, cur_day, cur_hour, cur_minute,
           cur_second, span_years, span_months, span_days, span_hours, span_min_sec,
    output ready
  );
endinterface

// Output channel: the shifted date-time per transaction.
interface cts_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] res_year;
  logic [3:0]         res_month;
  logic [4:0]         res_day;
  logic [4:0]         res_hour;
  logic [5:0]         res_minute;
  logic [5:0]         res_second;
  logic               res_valid;

  modport source (
    output valid, res_year, res_month, res_day, res_hour, res_minute, res_second,
           res_valid,
    input  ready
  );

  modport sink (
    input  valid, res_year, res_month, res_day, res_hour, res_minute, res_second,
           res_valid,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/cts_divmod.sv
`default_nettype none

// Shared floor divide by 60, 24, 12 or 400. The operand is biased to a
// non-negative value and registered, the quotient comes from a reciprocal
// multiply and is registered, and the remainder is formed from both.
module cts_divmod (
  input  logic                clk_i,
  input  cts_pkg::dm_ctrl_t   ctrl_i,
  input  logic signed [17:0]  op_i,
  output logic signed [8:0]   quot_o,
  output logic [8:0]          rem_o
);

  logic [16:0]       op_q;
  cts_pkg::div_sel_e sel_q;
  logic [7:0]        q_q;
  logic [39:0]       prod;
  logic [16:0]       back;
  logic [16:0]       rem_full;

  // Operand stage: add the bias that keeps the value non-negative.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q  <= 17'(op_i + $signed(18'(cts_pkg::div_bias(ctrl_i.sel))));
      sel_q <= ctrl_i.sel;
    end
  end

  // Multiply stage: quotient of the biased operand.
  assign prod = 40'(op_q) * 40'(cts_pkg::div_mult(sel_q));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      q_q <= prod[33:26];
    end
  end

  // Remainder and unbiased quotient.
  assign back     = 17'(q_q * cts_pkg::div_value(sel_q));
  assign rem_full = op_q - back;
  assign rem_o    = rem_full[8:0];
  assign quot_o   = 9'($signed(10'(q_q)) - $signed(10'(cts_pkg::div_k(sel_q))));

endmodule

`default_nettype wire

// File: rtl/core/cts_day_step.sv
`default_nettype none

// One month step of the day walk. Forward, the day moves to the first of the
// next month while the days left exceed the rest of this month. Backward, the
// day moves to the last of the previous month while the days left reach it.
module cts_day_step (
  input  logic                         sub_i,
  input  logic [3:0]                   month_i,
  input  logic signed [15:0]           year_i,
  input  logic [8:0]                   ymod_i,
  input  logic signed [7:0]            day_i,
  input  logic [cts_pkg::LEFT_W-1:0]   left_i,
  output cts_pkg::walk_t               next_o
);

  logic signed [12:0] day_w;
  logic signed [12:0] left_w;
  logic signed [12:0] delta;
  logic [4:0]         dim_cur;
  logic [4:0]         dim_prev;
  logic               wrap_up;
  logic               wrap_dn;
  logic [3:0]         month_up;
  logic [3:0]         month_dn;
  logic [8:0]         ymod_up;
  logic [8:0]         ymod_dn;
  logic [8:0]         ymod_prev;

  // Neighbouring months and their year remainders.
  always_comb begin
    day_w    = 13'(day_i);
    left_w   = $signed(13'(left_i));
    dim_cur  = cts_pkg::days_in(month_i, cts_pkg::is_leap(ymod_i));
    delta    = $signed(13'(dim_cur)) - day_w;
    wrap_up  = (month_i == cts_pkg::MONTH_DEC);
    wrap_dn  = (month_i == cts_pkg::MONTH_JAN);
    month_up = wrap_up ? cts_pkg::MONTH_JAN : month_i + 4'd1;
    month_dn = wrap_dn ? cts_pkg::MONTH_DEC : month_i - 4'd1;

    // The year wraps at the ends of its range, where the remainder jumps.
    if (year_i == cts_pkg::YEAR_MAX) begin
      ymod_up = cts_pkg::YMOD_AT_MIN;
    end else if (ymod_i == cts_pkg::YMOD_LAST) begin
      ymod_up = '0;
    end else begin
      ymod_up = ymod_i + 9'd1;
    end

    if (year_i == cts_pkg::YEAR_MIN) begin
      ymod_dn = cts_pkg::YMOD_AT_MAX;
    end else if (ymod_i == '0) begin
      ymod_dn = cts_pkg::YMOD_LAST;
    end else begin
      ymod_dn = ymod_i - 9'd1;
    end

    ymod_prev = wrap_dn ? ymod_dn : ymod_i;
    dim_prev  = cts_pkg::days_in(month_dn, cts_pkg::is_leap(ymod_prev));
  end

  // Step decision.
  always_comb begin
    next_o.month = month_i;
    next_o.year  = year_i;
    next_o.ymod  = ymod_i;
    next_o.day   = day_i;
    next_o.left  = left_i;
    next_o.done  = 1'b1;
    if (!sub_i) begin
      if (left_w > delta) begin
        next_o.month = month_up;
        if (wrap_up) begin
          next_o.year = year_i + 16'sd1;
          next_o.ymod = ymod_up;
        end
        next_o.day  = 8'sd1;
        next_o.left = cts_pkg::LEFT_W'(left_w - delta - 13'sd1);
        next_o.done = 1'b0;
      end else begin
        next_o.day = 8'(day_w + left_w);
      end
    end else begin
      if (left_w >= day_w) begin
        next_o.month = month_dn;
        if (wrap_dn) begin
          next_o.year = year_i - 16'sd1;
          next_o.ymod = ymod_dn;
        end
        next_o.day  = $signed(8'(dim_prev));
        next_o.left = cts_pkg::LEFT_W'(left_w - day_w);
        next_o.done = 1'b0;
      end else begin
        next_o.day = 8'(day_w - left_w);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/calendar_timestamp_add_sub.sv
// Channel   Direction   Transaction carries
// in_i      sink        action, starting date-time, span
// out_o     source      shifted date-time and day-in-month flag
//
// An item runs from acceptance to the loading of its result through the seconds,
// minutes, hours and year-remainder divides, the day walk with one step for each
// month visited, the month divide, the year sum, a second year-remainder divide
// and the finish. Each divide goes through the load, multiply and read phases.
// Reset clears the sequencer and the output valid; nothing else needs clearing.
// The input is ready only when idle; a waiting result stalls only the final load.
`default_nettype none

module calendar_timestamp_add_sub (
  input  logic      clk_i,
  input  logic      rst_ni,
  cts_in_if.sink    in_i,
  cts_out_if.source out_o
);

  cts_pkg::state_e     state_q, state_d;
  cts_pkg::div_phase_e phase_q, phase_d;

  // Working registers.
  logic                       sub_q;
  logic signed [15:0]         year_q;
  logic [3:0]                 month_q;
  logic signed [7:0]          day_q;
  logic [4:0]                 hour_q;
  logic [5:0]                 minute_q;
  logic [5:0]                 second_q;
  logic [8:0]                 ymod_q;
  logic [cts_pkg::LEFT_W-1:0] left_q;
  logic signed [8:0]          carry_q;
  logic [7:0]                 sy_q;
  logic [7:0]                 smo_q;
  logic [9:0]                 sh_q;
  logic [11:0]                smin_q;
  logic [11:0]                ssec_q;

  // Result registers.
  logic                       out_valid_q;
  logic signed [15:0]         res_year_q;
  logic [3:0]                 res_month_q;
  logic [4:0]                 res_day_q;
  logic [4:0]                 res_hour_q;
  logic [5:0]                 res_minute_q;
  logic [5:0]                 res_second_q;
  logic                       res_valid_q;

  logic                       in_fire;
  logic                       div_state;
  logic                       div_read;
  logic                       fin_load;
  cts_pkg::dm_ctrl_t          dm_ctrl;
  logic signed [17:0]         op_x;
  logic signed [17:0]         base_x;
  logic signed [17:0]         span_x;
  logic signed [17:0]         carry_x;
  logic signed [8:0]          dm_quot;
  logic [8:0]                 dm_rem;
  cts_pkg::walk_t             walk;
  logic [3:0]                 month_in;
  logic [9:0]                 sd_sat;
  logic [4:0]                 fin_dim;
  logic                       fin_ok;

  assign in_fire = in_i.valid && in_i.ready;

  assign div_state = (state_q == cts_pkg::ST_SEC)   || (state_q == cts_pkg::ST_MIN)   ||
                     (state_q == cts_pkg::ST_HOUR)  || (state_q == cts_pkg::ST_YMOD)  ||
                     (state_q == cts_pkg::ST_MONTH) || (state_q == cts_pkg::ST_YMOD2);
  assign div_read  = div_state && (phase_q == cts_pkg::PH_READ);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cts_pkg::ST_IDLE:   if (in_fire) state_d = cts_pkg::ST_SEC;
      cts_pkg::ST_SEC:    if (div_read) state_d = cts_pkg::ST_MIN;
      cts_pkg::ST_MIN:    if (div_read) state_d = cts_pkg::ST_HOUR;
      cts_pkg::ST_HOUR:   if (div_read) state_d = cts_pkg::ST_YMOD;
      cts_pkg::ST_YMOD:   if (div_read) state_d = cts_pkg::ST_WALK;
      cts_pkg::ST_WALK:   if (walk.done) state_d = cts_pkg::ST_MONTH;
      cts_pkg::ST_MONTH:  if (div_read) state_d = cts_pkg::ST_YEAR;
      cts_pkg::ST_YEAR:   state_d = cts_pkg::ST_YMOD2;
      cts_pkg::ST_YMOD2:  if (div_read) state_d = cts_pkg::ST_FINISH;
      cts_pkg::ST_FINISH: if (fin_load) state_d = cts_pkg::ST_IDLE;
      default:            state_d = cts_pkg::ST_IDLE;
    endcase

    phase_d = cts_pkg::PH_LOAD;
    if (div_state) begin
      case (phase_q)
        cts_pkg::PH_LOAD: phase_d = cts_pkg::PH_MUL;
        cts_pkg::PH_MUL:  phase_d = cts_pkg::PH_READ;
        default:          phase_d = cts_pkg::PH_LOAD;
      endcase
    end
  end

  // Sequencer outputs: handshake, divide control and the divide operand.
  always_comb begin
    in_i.ready   = (state_q == cts_pkg::ST_IDLE);
    fin_load     = (state_q == cts_pkg::ST_FINISH) && (!out_valid_q || out_o.ready);
    dm_ctrl.load = div_state && (phase_q == cts_pkg::PH_LOAD);
    dm_ctrl.mul  = div_state && (phase_q == cts_pkg::PH_MUL);
    dm_ctrl.sel  = cts_pkg::DIV_60;
    base_x       = '0;
    span_x       = '0;
    carry_x      = '0;
    case (state_q)
      cts_pkg::ST_SEC: begin
        base_x = $signed(18'(second_q));
        span_x = $signed(18'(ssec_q));
      end
      cts_pkg::ST_MIN: begin
        base_x  = $signed(18'(minute_q));
        span_x  = $signed(18'(smin_q));
        carry_x = 18'(carry_q);
      end
      cts_pkg::ST_HOUR: begin
        dm_ctrl.sel = cts_pkg::DIV_24;
        base_x      = $signed(18'(hour_q));
        span_x      = $signed(18'(sh_q));
        carry_x     = 18'(carry_q);
      end
      cts_pkg::ST_MONTH: begin
        dm_ctrl.sel = cts_pkg::DIV_12;
        base_x      = $signed(18'(month_q)) - 18'sd1;
        span_x      = $signed(18'(smo_q));
      end
      cts_pkg::ST_YMOD,
      cts_pkg::ST_YMOD2: begin
        dm_ctrl.sel = cts_pkg::DIV_400;
        base_x      = 18'(year_q);
      end
      default: begin
        dm_ctrl.sel = cts_pkg::DIV_60;
      end
    endcase
    op_x = base_x + carry_x + (sub_q ? -span_x : span_x);
  end

  // Shared divide unit.
  cts_divmod u_divmod (
    .clk_i  (clk_i),
    .ctrl_i (dm_ctrl),
    .op_i   (op_x),
    .quot_o (dm_quot),
    .rem_o  (dm_rem)
  );

  // One month of the day walk.
  cts_day_step u_day_step (
    .sub_i   (sub_q),
    .month_i (month_q),
    .year_i  (year_q),
    .ymod_i  (ymod_q),
    .day_i   (day_q),
    .left_i  (left_q),
    .next_o  (walk)
  );

  // Input normalisation: month into 1..12, day span saturated.
  always_comb begin
    if (in_i.cur_month < cts_pkg::MONTH_JAN) begin
      month_in = cts_pkg::MONTH_JAN;
    end else if (in_i.cur_month > cts_pkg::MONTH_DEC) begin
      month_in = cts_pkg::MONTH_DEC;
    end else begin
      month_in = in_i.cur_month;
    end
    if (32'(in_i.span_days) > cts_pkg::MAX_SPAN_DAYS) begin
      sd_sat = 10'(cts_pkg::MAX_SPAN_DAYS);
    end else begin
      sd_sat = in_i.span_days;
    end
  end

  // Day-in-month check on the final date.
  assign fin_dim = cts_pkg::days_in(month_q, cts_pkg::is_leap(ymod_q));
  assign fin_ok  = (day_q > 8'sd0) && (day_q <= $signed(8'(fin_dim)));

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cts_pkg::ST_IDLE;
      phase_q     <= cts_pkg::PH_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers, updated by the step in progress.
  always_ff @(posedge clk_i) begin
    case (state_q)
      cts_pkg::ST_IDLE: begin
        if (in_fire) begin
          sub_q    <= in_i.action;
          year_q   <= in_i.cur_year;
          month_q  <= month_in;
          day_q    <= $signed(8'(in_i.cur_day));
          hour_q   <= in_i.cur_hour;
          minute_q <= in_i.cur_minute;
          second_q <= in_i.cur_second;
          sy_q     <= in_i.span_years;
          smo_q    <= in_i.span_months;
          left_q   <= cts_pkg::LEFT_W'(sd_sat);
          sh_q     <= in_i.span_hours;
          smin_q   <= in_i.span_min_sec[23:12];
          ssec_q   <= in_i.span_min_sec[11:0];
        end
      end
      cts_pkg::ST_SEC: begin
        if (div_read) begin
          second_q <= dm_rem[5:0];
          carry_q  <= dm_quot;
        end
      end
      cts_pkg::ST_MIN: begin
        if (div_read) begin
          minute_q <= dm_rem[5:0];
          carry_q  <= dm_quot;
        end
      end
      cts_pkg::ST_HOUR: begin
        if (div_read) begin
          hour_q <= dm_rem[4:0];
          day_q  <= day_q + 8'(dm_quot);
        end
      end
      cts_pkg::ST_YMOD,
      cts_pkg::ST_YMOD2: begin
        if (div_read) begin
          ymod_q <= dm_rem;
        end
      end
      cts_pkg::ST_WALK: begin
        month_q <= walk.month;
        year_q  <= walk.year;
        ymod_q  <= walk.ymod;
        day_q   <= walk.day;
        left_q  <= walk.left;
      end
      cts_pkg::ST_MONTH: begin
        if (div_read) begin
          month_q <= dm_rem[3:0] + 4'd1;
          carry_q <= dm_quot;
        end
      end
      cts_pkg::ST_YEAR: begin
        year_q <= year_q + 16'(carry_q) +
                  (sub_q ? -$signed(16'(sy_q)) : $signed(16'(sy_q)));
      end
      default: begin
        sub_q <= sub_q;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      res_year_q   <= year_q;
      res_month_q  <= month_q;
      res_day_q    <= day_q[4:0];
      res_hour_q   <= hour_q;
      res_minute_q <= minute_q;
      res_second_q <= second_q;
      res_valid_q  <= fin_ok;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.res_year   = res_year_q;
  assign out_o.res_month  = res_month_q;
  assign out_o.res_day    = res_day_q;
  assign out_o.res_hour   = res_hour_q;
  assign out_o.res_minute = res_minute_q;
  assign out_o.res_second = res_second_q;
  assign out_o.res_valid  = res_valid_q;

  // A result appears only from the final load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == cts_pkg::ST_FINISH)
    else $error("result appeared outside the final load");

  // A free output register is always loaded on the first finishing cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cts_pkg::ST_FINISH && !out_valid_q) |=>
      (state_q == cts_pkg::ST_IDLE && out_valid_q))
    else $error("finished item was not delivered to a free output register");

  // An accepted item starts the divide chain at its first phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == cts_pkg::ST_SEC && phase_q == cts_pkg::PH_LOAD))
    else $error("accepted item did not start at the seconds divide");

  // The walk keeps the month and year remainder in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cts_pkg::ST_WALK |->
      (month_q >= cts_pkg::MONTH_JAN && month_q <= cts_pkg::MONTH_DEC &&
       ymod_q <= cts_pkg::YMOD_LAST))
    else $error("month or year remainder out of range during the walk");

  // Delivered clock fields and month are normalised.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |->
      (res_month_q >= cts_pkg::MONTH_JAN && res_month_q <= cts_pkg::MONTH_DEC &&
       res_hour_q < cts_pkg::HOURS_PER_DAY && res_minute_q < cts_pkg::MINS_PER_HOUR &&
       res_second_q < cts_pkg::SECS_PER_MINUTE))
    else $error("result field out of range");

endmodule

`default_nettype wire
